### design/first_fit_free_list_allocator_macros.svh
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define FFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Check that cons holds in the cycle after ante.
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### design/ffa_pkg.sv
package ffa_pkg;

  // Field widths of the command and result ports
  localparam int unsigned REQ_W    = 10;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned STATUS_W = 3;
  // Rounded request size, up to 1024 bytes
  localparam int unsigned SIZE_W   = 11;

  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned OCC_FLAG   = 1;
  // Largest rounded request plus one header word: bounds what a split can write
  localparam int unsigned SLACK_BYTES = 1028;

  // Command codes
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd4;

  // Result handed from the walker to the output stage
  typedef struct packed {
    logic                done;
    logic                ok;
    logic [OFF_W-1:0]    payload_offset;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

### design/ffa_heap_mem.sv
module ffa_heap_mem #(
  parameter int unsigned HEAP_WORDS = 256
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    rd_en_i,
  input  logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES):0]      rd_addr_i,
  output logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES)-1:0]    rd_data_o,
  input  logic                                                    wr_en_i,
  input  logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES):0]      wr_addr_i,
  input  logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES)-1:0]    wr_data_i
);

  localparam int unsigned DW = $clog2(HEAP_WORDS*4 + ffa_pkg::SLACK_BYTES);
  localparam int unsigned AW = DW + 1;
  localparam int unsigned IW = $clog2(HEAP_WORDS);
  localparam logic [AW-1:0] WORDS_A = AW'(HEAP_WORDS);

  logic [DW-1:0] mem_q [HEAP_WORDS];
  logic [DW-1:0] rdata_q;
  logic          oob_q;
  logic          rd_in, wr_in;

  // Byte addresses past the last word fall outside the store
  assign rd_in = (rd_addr_i >> 2) < WORDS_A;
  assign wr_in = (wr_addr_i >> 2) < WORDS_A;

  // Drop writes outside the store
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in) begin
      mem_q[wr_addr_i[IW+1:2]] <= wr_data_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i && rd_in) begin
      rdata_q <= mem_q[rd_addr_i[IW+1:2]];
    end
  end

  // Remember an out-of-range read so it returns zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oob_q <= 1'b0;
    end else if (rd_en_i) begin
      oob_q <= !rd_in;
    end
  end

  assign rd_data_o = oob_q ? '0 : rdata_q;

endmodule

### design/ffa_walker.sv
module ffa_walker #(
  parameter int unsigned HEAP_WORDS = 256
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    start,
  input  logic                                                    cmd_i,
  input  logic [ffa_pkg::REQ_W-1:0]                               request_bytes_i,
  input  logic [ffa_pkg::OFF_W-1:0]                               block_offset_i,
  output logic                                                    busy_o,
  output ffa_pkg::result_t                                        res_o,
  output logic                                                    rd_en_o,
  output logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES):0]      rd_addr_o,
  input  logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES)-1:0]    rd_data_i,
  output logic                                                    wr_en_o,
  output logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES):0]      wr_addr_o,
  output logic [$clog2(HEAP_WORDS*4+ffa_pkg::SLACK_BYTES)-1:0]    wr_data_o
);

  localparam int unsigned DW = $clog2(HEAP_WORDS*4 + ffa_pkg::SLACK_BYTES);
  localparam int unsigned AW = DW + 1;
  localparam int unsigned IW = $clog2(HEAP_WORDS);
  localparam int unsigned SW = ffa_pkg::SIZE_W;

  localparam logic [DW-1:0] HEAP_BYTES_D = DW'(HEAP_WORDS*4);
  localparam logic [DW-1:0] WORD_D       = DW'(ffa_pkg::WORD_BYTES);
  localparam logic [DW-1:0] OCC_D        = DW'(ffa_pkg::OCC_FLAG);
  localparam logic [AW-1:0] WORD_A       = AW'(ffa_pkg::WORD_BYTES);
  localparam logic [AW-1:0] WORDS_A      = AW'(HEAP_WORDS);
  localparam logic [IW-1:0] N_LAST       = IW'(HEAP_WORDS-1);
  localparam logic [SW-1:0] RND_ADD      = SW'(ffa_pkg::WORD_BYTES-1);

  typedef enum logic [10:0] {
    S_INIT_SIZE  = 11'b000_0000_0001,
    S_INIT_LINK  = 11'b000_0000_0010,
    S_IDLE       = 11'b000_0000_0100,
    S_WALK_LINK  = 11'b000_0000_1000,
    S_WALK_EVAL  = 11'b000_0001_0000,
    S_WR_HDR     = 11'b000_0010_0000,
    S_WR_NB_SIZE = 11'b000_0100_0000,
    S_WR_NB_LINK = 11'b000_1000_0000,
    S_WR_PARENT  = 11'b001_0000_0000,
    S_FREE_EVAL  = 11'b010_0000_0000,
    S_FREE_LINK  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [DW-1:0] head_q, head_d;
  logic [DW-1:0] cur_q, cur_d;
  logic [DW-1:0] par_q, par_d;
  logic [DW-1:0] fs_q, fs_d;
  logic [DW-1:0] nxt_q, nxt_d;
  logic [DW-1:0] repl_q, repl_d;
  logic [SW-1:0] sz_q, sz_d;
  logic [IW-1:0] n_q, n_d;
  logic          at_head_q, at_head_d;
  logic [ffa_pkg::OFF_W-1:0] ptr_q, ptr_d;

  logic          head_null, rd_null, fits, exact;
  logic [SW-1:0] sz_round;
  logic [DW-1:0] sz_dw, ptr_dw;
  logic [AW-1:0] cur_a, nb_a, ptr_a, cur_pl_a;

  // Decode helpers
  assign head_null = head_q >= HEAP_BYTES_D;
  assign rd_null   = rd_data_i >= HEAP_BYTES_D;
  assign sz_round  = (SW'(request_bytes_i) + RND_ADD) & ~RND_ADD;
  assign sz_dw     = DW'(sz_q);
  assign fits      = fs_q >= sz_dw;
  assign exact     = (fs_q == sz_dw) || (fs_q == sz_dw + WORD_D);
  assign cur_a     = AW'(cur_q);
  assign cur_pl_a  = cur_a + WORD_A;
  assign nb_a      = cur_a + AW'(sz_q) + WORD_A;
  assign ptr_dw    = DW'(block_offset_i);
  assign ptr_a     = AW'(ptr_q);

  // Sequence the memory accesses of one request
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cur_d     = cur_q;
    par_d     = par_q;
    fs_d      = fs_q;
    nxt_d     = nxt_q;
    repl_d    = repl_q;
    sz_d      = sz_q;
    n_d       = n_q;
    at_head_d = at_head_q;
    ptr_d     = ptr_q;
    rd_en_o   = 1'b0;
    rd_addr_o = cur_a;
    wr_en_o   = 1'b0;
    wr_addr_o = cur_a;
    wr_data_o = '0;
    res_o     = '0;

    unique case (state_q)
      S_INIT_SIZE: begin
        wr_en_o   = 1'b1;
        wr_addr_o = '0;
        wr_data_o = HEAP_BYTES_D - WORD_D;
        state_d   = S_INIT_LINK;
      end
      S_INIT_LINK: begin
        wr_en_o   = 1'b1;
        wr_addr_o = WORD_A;
        wr_data_o = HEAP_BYTES_D;
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (cmd_i == ffa_pkg::CMD_ALLOC) begin
            if (head_null) begin
              res_o = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_NOSPACE};
            end else if (request_bytes_i == '0) begin
              res_o = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_ZERO};
            end else begin
              sz_d      = sz_round;
              cur_d     = head_q;
              at_head_d = 1'b1;
              n_d       = '0;
              rd_en_o   = 1'b1;
              rd_addr_o = AW'(head_q);
              state_d   = S_WALK_LINK;
            end
          end else begin
            if (!head_null && (ptr_dw == head_q)) begin
              res_o = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_NOTALLOC};
            end else if (block_offset_i[1:0] != 2'b00) begin
              res_o = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_MISALIGN};
            end else if ((ptr_dw < WORD_D) || ((AW'(block_offset_i) >> 2) >= WORDS_A)) begin
              res_o = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_NOTALLOC};
            end else begin
              ptr_d     = block_offset_i;
              rd_en_o   = 1'b1;
              rd_addr_o = AW'(block_offset_i) - WORD_A;
              state_d   = S_FREE_EVAL;
            end
          end
        end
      end
      S_WALK_LINK: begin
        // Capture the block size, fetch its link
        fs_d      = rd_data_i;
        rd_en_o   = 1'b1;
        rd_addr_o = cur_pl_a;
        state_d   = S_WALK_EVAL;
      end
      S_WALK_EVAL: begin
        nxt_d = rd_data_i;
        if (fits) begin
          state_d = S_WR_HDR;
        end else if (rd_null || (n_q == N_LAST)) begin
          res_o   = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_NOSPACE};
          state_d = S_IDLE;
        end else begin
          // Advance to the next free block
          par_d     = cur_q;
          cur_d     = rd_data_i;
          at_head_d = 1'b0;
          n_d       = n_q + IW'(1);
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(rd_data_i);
          state_d   = S_WALK_LINK;
        end
      end
      S_WR_HDR: begin
        // Mark the block occupied; split off the tail unless it is too small
        wr_en_o   = 1'b1;
        wr_addr_o = cur_a;
        wr_data_o = exact ? (fs_q | OCC_D) : (sz_dw | OCC_D);
        repl_d    = exact ? nxt_q : nb_a[DW-1:0];
        if (!exact) begin
          state_d = S_WR_NB_SIZE;
        end else if (at_head_q) begin
          head_d  = repl_d;
          res_o   = '{done: 1'b1, ok: 1'b1, payload_offset: cur_pl_a[ffa_pkg::OFF_W-1:0],
                      status: ffa_pkg::ST_OK};
          state_d = S_IDLE;
        end else begin
          state_d = S_WR_PARENT;
        end
      end
      S_WR_NB_SIZE: begin
        wr_en_o   = 1'b1;
        wr_addr_o = AW'(repl_q);
        wr_data_o = fs_q - (sz_dw + WORD_D);
        state_d   = S_WR_NB_LINK;
      end
      S_WR_NB_LINK: begin
        wr_en_o   = 1'b1;
        wr_addr_o = AW'(repl_q) + WORD_A;
        wr_data_o = nxt_q;
        if (at_head_q) begin
          head_d  = repl_q;
          res_o   = '{done: 1'b1, ok: 1'b1, payload_offset: cur_pl_a[ffa_pkg::OFF_W-1:0],
                      status: ffa_pkg::ST_OK};
          state_d = S_IDLE;
        end else begin
          state_d = S_WR_PARENT;
        end
      end
      S_WR_PARENT: begin
        // Relink the parent to the replacement
        wr_en_o   = 1'b1;
        wr_addr_o = AW'(par_q) + WORD_A;
        wr_data_o = repl_q;
        res_o     = '{done: 1'b1, ok: 1'b1, payload_offset: cur_pl_a[ffa_pkg::OFF_W-1:0],
                      status: ffa_pkg::ST_OK};
        state_d   = S_IDLE;
      end
      S_FREE_EVAL: begin
        if (rd_data_i[0] == 1'b0) begin
          res_o   = '{done: 1'b1, ok: 1'b0, payload_offset: '0, status: ffa_pkg::ST_NOTALLOC};
          state_d = S_IDLE;
        end else begin
          wr_en_o   = 1'b1;
          wr_addr_o = ptr_a - WORD_A;
          wr_data_o = rd_data_i & ~OCC_D;
          state_d   = S_FREE_LINK;
        end
      end
      S_FREE_LINK: begin
        // Push the block at the head of the chain
        wr_en_o   = 1'b1;
        wr_addr_o = ptr_a;
        wr_data_o = head_null ? HEAP_BYTES_D : head_q;
        head_d    = DW'(ptr_q) - WORD_D;
        res_o     = '{done: 1'b1, ok: 1'b1, payload_offset: '0, status: ffa_pkg::ST_OK};
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_SIZE;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
    end
  end

  // Hold walk context
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    par_q     <= par_d;
    fs_q      <= fs_d;
    nxt_q     <= nxt_d;
    repl_q    <= repl_d;
    sz_q      <= sz_d;
    n_q       <= n_d;
    at_head_q <= at_head_d;
    ptr_q     <= ptr_d;
  end

endmodule

### design/first_fit_free_list_allocator.sv
// A free is rejected up front or after reading its header if that is free; else it clears
// the flag and writes the link. An allocate reads size, then link, of each block visited
// (one word port), then on a fit does 1 to 4 writes (header, split tail, parent link).
// Throughput: one request at a time; start is taken whenever busy is low.
// Reset: asynchronous, active low; busy stays high while the initial block is written.
// Each result is registered, shown for one cycle under done_o; the receiver cannot stall.
`include "first_fit_free_list_allocator_macros.svh"

module first_fit_free_list_allocator #(
  parameter int unsigned HEAP_WORDS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [ffa_pkg::REQ_W-1:0]      request_bytes_i,
  input  logic [ffa_pkg::OFF_W-1:0]      block_offset_i,
  output logic                           done_o,
  output logic                           ok_o,
  output logic [ffa_pkg::OFF_W-1:0]      payload_offset_o,
  output logic [ffa_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned DW = $clog2(HEAP_WORDS*4 + ffa_pkg::SLACK_BYTES);
  localparam int unsigned AW = DW + 1;

  ffa_pkg::result_t res;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;
  logic          done_q;
  logic          ok_q;
  logic [ffa_pkg::OFF_W-1:0]    offset_q;
  logic [ffa_pkg::STATUS_W-1:0] status_q;

  ffa_walker #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .request_bytes_i(request_bytes_i),
    .block_offset_i (block_offset_i),
    .busy_o         (busy),
    .res_o          (res),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  ffa_heap_mem #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_heap_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // Strobe each result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.done;
    end
  end

  // Register the result fields
  always_ff @(posedge clk_i) begin
    if (res.done) begin
      ok_q     <= res.ok;
      offset_q <= res.payload_offset;
      status_q <= res.status;
    end
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign payload_offset_o = offset_q;
  assign status_o         = status_q;

  `FFA_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy, busy || done_o)
  `FFA_ASSERT_SAME(a_ok_matches_status, clk_i, rst_ni, done_o, ok_o == (status_o == ffa_pkg::ST_OK))
  `FFA_ASSERT_SAME(a_fail_zero_offset, clk_i, rst_ni, done_o && !ok_o, payload_offset_o == '0)

endmodule

### test/tb.sv
module tb;

  localparam int unsigned HEAP_WORDS   = 256;
  localparam int unsigned HEAP_BYTES   = HEAP_WORDS * ffa_pkg::WORD_BYTES;
  localparam int unsigned LINK_NULL    = HEAP_BYTES;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned RANDOM_ITEMS = 1880;

  typedef struct packed {
    logic                         ok;
    logic [ffa_pkg::OFF_W-1:0]    payload_offset;
    logic [ffa_pkg::STATUS_W-1:0] status;
  } outcome_t;

  // Shadow heap: predicts each outcome and checks the block's results in order
  class heap_tracker;
    logic [ffa_pkg::SIZE_W-1:0] words[HEAP_WORDS];
    bit                written[HEAP_WORDS];
    int unsigned       head;
    int unsigned       live[$];
    outcome_t          pending[$];
    int unsigned       errors;

    function new();
      foreach (words[i]) begin
        words[i]   = '0;
        written[i] = 1'b0;
      end
      words[0]   = ffa_pkg::SIZE_W'(HEAP_BYTES - ffa_pkg::WORD_BYTES);
      words[1]   = ffa_pkg::SIZE_W'(LINK_NULL);
      written[0] = 1'b1;
      written[1] = 1'b1;
      head       = 0;
      errors     = 0;
    endfunction

    function int unsigned read_word(int unsigned addr);
      if ((addr >> 2) >= HEAP_WORDS) return 0;
      return int'(words[addr >> 2]);
    endfunction

    // Drop writes that fall outside the heap
    function void write_word(int unsigned addr, int unsigned value);
      if ((addr >> 2) < HEAP_WORDS) begin
        words[addr >> 2]   = ffa_pkg::SIZE_W'(value);
        written[addr >> 2] = 1'b1;
      end
    endfunction

    // Walk the chain first-fit; take the whole block or split off the tail
    function outcome_t predict_alloc(int unsigned req);
      outcome_t    res;
      int unsigned size, cur, par, fs, nxt, repl, tail;
      bit          at_head;
      res = outcome_t'({1'b0, ffa_pkg::OFF_W'(0), ffa_pkg::ST_NOSPACE});
      if (head >= LINK_NULL) return res;
      if (req == 0) begin
        res.status = ffa_pkg::ST_ZERO;
        return res;
      end
      size    = (req + 3) & ~32'd3;
      cur     = head;
      par     = head;
      at_head = 1'b1;
      for (int unsigned n = 0; n < HEAP_WORDS; n++) begin
        fs  = read_word(cur);
        nxt = read_word(cur + ffa_pkg::WORD_BYTES);
        if (fs >= size) begin
          if (fs == size || fs == size + ffa_pkg::WORD_BYTES) begin
            write_word(cur, fs | ffa_pkg::OCC_FLAG);
            repl = nxt;
          end else begin
            tail = cur + size + ffa_pkg::WORD_BYTES;
            write_word(cur, size | ffa_pkg::OCC_FLAG);
            write_word(tail, fs - size - ffa_pkg::WORD_BYTES);
            write_word(tail + ffa_pkg::WORD_BYTES, nxt);
            repl = tail;
          end
          if (at_head) head = repl;
          else write_word(par + ffa_pkg::WORD_BYTES, repl);
          res.ok             = 1'b1;
          res.status         = ffa_pkg::ST_OK;
          res.payload_offset = ffa_pkg::OFF_W'(cur + ffa_pkg::WORD_BYTES);
          live.push_back(cur + ffa_pkg::WORD_BYTES);
          return res;
        end
        if (nxt >= LINK_NULL) return res;
        par     = cur;
        cur     = nxt;
        at_head = 1'b0;
      end
      return res;
    endfunction

    // Reject bad offsets, else clear the occupied flag and push at the head
    function outcome_t predict_free(int unsigned ptr);
      outcome_t    res;
      int unsigned hv;
      res = outcome_t'({1'b0, ffa_pkg::OFF_W'(0), ffa_pkg::ST_NOTALLOC});
      if (head < LINK_NULL && ptr == head) return res;
      if ((ptr & 3) != 0) begin
        res.status = ffa_pkg::ST_MISALIGN;
        return res;
      end
      if (ptr < ffa_pkg::WORD_BYTES || (ptr >> 2) >= HEAP_WORDS) return res;
      hv = read_word(ptr - ffa_pkg::WORD_BYTES);
      if ((hv & ffa_pkg::OCC_FLAG) == 0) return res;
      write_word(ptr - ffa_pkg::WORD_BYTES, hv & ~ffa_pkg::OCC_FLAG);
      write_word(ptr, (head >= LINK_NULL) ? LINK_NULL : head);
      head       = ptr - ffa_pkg::WORD_BYTES;
      res.ok     = 1'b1;
      res.status = ffa_pkg::ST_OK;
      for (int i = 0; i < live.size(); i++) begin
        if (live[i] == ptr) begin
          live.delete(i);
          break;
        end
      end
      return res;
    endfunction

    // True when freeing ptr would read a heap word never written
    function bit reads_blank(int unsigned ptr);
      if (head < LINK_NULL && ptr == head) return 1'b0;
      if ((ptr & 3) != 0 || ptr < ffa_pkg::WORD_BYTES || (ptr >> 2) >= HEAP_WORDS) return 1'b0;
      return !written[(ptr - ffa_pkg::WORD_BYTES) >> 2];
    endfunction

    // Size of a free block a few links down the chain, zero when empty
    function int unsigned free_block_size();
      int unsigned cur, nxt, steps;
      if (head >= LINK_NULL) return 0;
      cur   = head;
      steps = $urandom_range(0, 15);
      for (int unsigned k = 0; k < steps; k++) begin
        nxt = read_word(cur + ffa_pkg::WORD_BYTES);
        if (nxt >= LINK_NULL) break;
        cur = nxt;
      end
      return read_word(cur);
    endfunction

    function void note_request(ffa_pkg::cmd_e cmd, int unsigned req, int unsigned off);
      if (cmd == ffa_pkg::CMD_ALLOC) pending.push_back(predict_alloc(req));
      else pending.push_back(predict_free(off));
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: ok=%0d offset=%0d status=%0d",
                   got.ok, got.payload_offset, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.ok !== want.ok || got.payload_offset !== want.payload_offset ||
          got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ok=%0d offset=%0d status=%0d, got ok=%0d offset=%0d status=%0d",
                   want.ok, want.payload_offset, want.status,
                   got.ok, got.payload_offset, got.status);
      end
    endfunction
  endclass

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic              cmd_i           = 1'b0;
  logic [ffa_pkg::REQ_W-1:0]  request_bytes_i = '0;
  logic [ffa_pkg::OFF_W-1:0]  block_offset_i  = '0;
  logic              done_o;
  logic              ok_o;
  logic [ffa_pkg::OFF_W-1:0]  payload_offset_o;
  logic [ffa_pkg::STATUS_W-1:0] status_o;

  heap_tracker shadow;
  int unsigned idle_cycles = 0;
  bit          no_gaps     = 1'b0;

  first_fit_free_list_allocator #(
    .HEAP_WORDS(HEAP_WORDS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .request_bytes_i (request_bytes_i),
    .block_offset_i  (block_offset_i),
    .done_o          (done_o),
    .ok_o            (ok_o),
    .payload_offset_o(payload_offset_o),
    .status_o        (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Hold start until the transfer, then record the expected outcome
  task automatic issue(ffa_pkg::cmd_e cmd, int unsigned req, int unsigned off);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    cmd_i           <= cmd;
    request_bytes_i <= ffa_pkg::REQ_W'(req);
    block_offset_i  <= ffa_pkg::OFF_W'(off);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    shadow.note_request(cmd, int'(ffa_pkg::REQ_W'(req)), int'(ffa_pkg::OFF_W'(off)));
  endtask

  task automatic issue_alloc(int unsigned req);
    issue(ffa_pkg::CMD_ALLOC, req, $urandom_range(0, 1023));
  endtask

  task automatic issue_free(int unsigned off);
    issue(ffa_pkg::CMD_FREE, $urandom_range(0, 1023), off);
  endtask

  // Check every result strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      shadow.check_result(outcome_t'({ok_o, payload_offset_o, status_o}));
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned pick, size, off;
    shadow = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Free of the head, misaligned offsets, free of an unoccupied header
    issue_free(0);
    issue_free(2);
    issue_free(1023);
    issue_free(4);
    // Zero size, split, too large, exact fit emptying the chain
    issue_alloc(0);
    issue_alloc(1);
    issue_alloc(1023);
    issue_alloc(1012);
    // Empty chain beats zero size; free below the first payload word
    issue_alloc(5);
    issue_alloc(0);
    issue_free(0);
    // Free into an empty chain, then a double free
    issue_free(12);
    issue_free(4);
    issue_free(4);
    // Exact fit at the head, split, and a 4-byte excess
    issue_alloc(4);
    issue_alloc(8);
    issue_alloc(996);
    // Build a three-block chain; unlink in the middle, at the end, at the head
    issue_free(24);
    issue_free(12);
    issue_free(4);
    issue_alloc(8);
    issue_alloc(1000);
    issue_alloc(2);

    // Random mix: mostly live frees and fitting allocs, some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40 && shadow.live.size() != 0) begin
        issue_free(shadow.live[$urandom_range(0, shadow.live.size() - 1)]);
      end else if (pick < 68) begin
        issue_alloc($urandom_range(1, 48));
      end else if (pick < 82) begin
        size = shadow.free_block_size();
        case ($urandom_range(0, 2))
          0: ;
          1: size = (size >= ffa_pkg::WORD_BYTES) ? size - ffa_pkg::WORD_BYTES : size;
          default: size = (size >= 3) ? size - $urandom_range(0, 3) : size;
        endcase
        if (size == 0) size = $urandom_range(1, 64);
        issue_alloc(size);
      end else if (pick < 88) begin
        issue_alloc($urandom_range(0, 1023));
      end else if (pick < 90) begin
        issue_alloc(0);
      end else if (pick < 93) begin
        issue_free(shadow.head);
      end else begin
        off = $urandom_range(0, 1023);
        while (shadow.reads_blank(off)) off = $urandom_range(0, 1023);
        issue_free(off);
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then watch a little longer for strays
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (shadow.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/ffa_pkg.sv
design/ffa_heap_mem.sv
design/ffa_walker.sv
design/first_fit_free_list_allocator.sv
test/tb.sv
